// File: design/swept_box_collision_test_defines.svh
// Assertion macros used by the swept box collision test top level.
`ifndef SWEPT_BOX_COLLISION_TEST_DEFINES_SVH
`define SWEPT_BOX_COLLISION_TEST_DEFINES_SVH
`ifndef SYNTH
// clocked check, disabled while reset is asserted
`define SBCT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("swept box collision check failed");
// clocked check that also runs during reset
`define SBCT_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("swept box collision reset check failed");
`else
`define SBCT_ASSERT(lbl, clk, rstn, prop)
`define SBCT_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: design/sbct_pkg.sv
// Types, widths and constants of the swept box collision test.
package sbct_pkg;

    // fraction bits of the internal time values
    localparam int FRAC_BITS  = 16;
    // magnitude of an entry/exit distance in pixels
    localparam int DIST_W     = 17;
    // magnitude of a Q16.8 displacement
    localparam int DEN_W      = 24;
    localparam int NUM_W      = DIST_W + 8 + FRAC_BITS;
    localparam int Q_W        = NUM_W + 2;
    localparam int DIV_STAGES = NUM_W;
    localparam int E_SHR      = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int E_SHL      = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam logic signed [Q_W-1:0] ONE_TIME = Q_W'(1) <<< FRAC_BITS;
    localparam logic [7:0]            FT_RESET = 8'd16;

    localparam logic signed [1:0] NORM_ZERO = 2'sb00;
    localparam logic signed [1:0] NORM_POS  = 2'sb01;
    localparam logic signed [1:0] NORM_NEG  = 2'sb11;

    // one input request
    typedef struct packed {
        logic signed [15:0] first_left;
        logic signed [15:0] first_top;
        logic [11:0]        first_width;
        logic [11:0]        first_height;
        logic signed [15:0] second_left;
        logic signed [15:0] second_top;
        logic [11:0]        second_width;
        logic [11:0]        second_height;
        logic signed [15:0] first_speed_x;
        logic signed [15:0] first_speed_y;
        logic signed [15:0] second_speed_x;
        logic signed [15:0] second_speed_y;
    } in_item_t;

    // unsigned division request
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic [NUM_W-1:0] quo;
        logic             rem_nz;
    } div_res_t;

    // flags that ride alongside the dividers
    typedef struct packed {
        logic       nohit;
        logic       xinf;
        logic       yinf;
        logic       xe_neg;
        logic       ye_neg;
        logic [3:0] qneg;   // xe, xx, ye, yx quotient signs
    } side_t;

endpackage

// File: design/swept_box_collision_test.sv
// Top level of the swept box collision test pipeline.
//
//  channel   ports                          direction  content
//  s_        s_valid/s_ready + 12 fields    in         one box pair request
//  m_        m_valid/m_ready + 4 fields     out        hit, entry time, normal
//  cfg_      cfg_valid/cfg_ready, cfg_data  in         frame_time register
//
// One request per cycle while the result is not held; 4 front stages, 41 divider
// stages (one quotient bit each), 2 back stages.
// The four time divisions run in parallel pipelined dividers.
// Synchronous active-low reset clears all valid bits; frame_time resets to 16.
// A stall at the result holds the whole pipeline; nothing is lost or repeated.
`include "swept_box_collision_test_defines.svh"

module swept_box_collision_test (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_first_left,
    input  logic signed [15:0] s_first_top,
    input  logic [11:0]        s_first_width,
    input  logic [11:0]        s_first_height,
    input  logic signed [15:0] s_second_left,
    input  logic signed [15:0] s_second_top,
    input  logic [11:0]        s_second_width,
    input  logic [11:0]        s_second_height,
    input  logic signed [15:0] s_first_speed_x,
    input  logic signed [15:0] s_first_speed_y,
    input  logic signed [15:0] s_second_speed_x,
    input  logic signed [15:0] s_second_speed_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [16:0]        m_entry_time,
    output logic signed [1:0]  m_normal_x,
    output logic signed [1:0]  m_normal_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    // frame time register
    logic [7:0] frame_time_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_time_reg <= sbct_pkg::FT_RESET;
        end else if (cfg_valid) begin
            frame_time_reg <= cfg_data;
        end
    end

    // whole pipeline advances unless the result is held
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    sbct_pkg::in_item_t in_item;
    always_comb begin
        in_item.first_left     = s_first_left;
        in_item.first_top      = s_first_top;
        in_item.first_width    = s_first_width;
        in_item.first_height   = s_first_height;
        in_item.second_left    = s_second_left;
        in_item.second_top     = s_second_top;
        in_item.second_width   = s_second_width;
        in_item.second_height  = s_second_height;
        in_item.first_speed_x  = s_first_speed_x;
        in_item.first_speed_y  = s_first_speed_y;
        in_item.second_speed_x = s_second_speed_x;
        in_item.second_speed_y = s_second_speed_y;
    end

    logic               front_valid;
    sbct_pkg::side_t    front_side;
    sbct_pkg::div_req_t req_xe, req_xx, req_ye, req_yx;
    sbct_pkg::div_res_t res_xe, res_xx, res_ye, res_yx;

    sbct_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .in_item    (in_item),
        .frame_time (frame_time_reg),
        .out_valid  (front_valid),
        .out_side   (front_side),
        .req_xe     (req_xe),
        .req_xx     (req_xx),
        .req_ye     (req_ye),
        .req_yx     (req_yx)
    );

    sbct_div u_div_xe (.aclk(aclk), .en(en), .req(req_xe), .res(res_xe));
    sbct_div u_div_xx (.aclk(aclk), .en(en), .req(req_xx), .res(res_xx));
    sbct_div u_div_ye (.aclk(aclk), .en(en), .req(req_ye), .res(res_ye));
    sbct_div u_div_yx (.aclk(aclk), .en(en), .req(req_yx), .res(res_yx));

    // flags and valid bits travel beside the dividers
    logic            dv_reg   [sbct_pkg::DIV_STAGES];
    sbct_pkg::side_t dside_reg[sbct_pkg::DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            dside_reg[0] <= front_side;
            for (int i = 1; i < sbct_pkg::DIV_STAGES; i++) begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < sbct_pkg::DIV_STAGES; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end else if (en) begin
            dv_reg[0] <= front_valid;
            for (int i = 1; i < sbct_pkg::DIV_STAGES; i++) begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    sbct_post u_post (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (dv_reg[sbct_pkg::DIV_STAGES-1]),
        .in_side        (dside_reg[sbct_pkg::DIV_STAGES-1]),
        .res_xe         (res_xe),
        .res_xx         (res_xx),
        .res_ye         (res_ye),
        .res_yx         (res_yx),
        .out_valid      (m_valid),
        .out_hit        (m_hit),
        .out_entry_time (m_entry_time),
        .out_normal_x   (m_normal_x),
        .out_normal_y   (m_normal_y)
    );

    // checks
    `SBCT_ASSERT_NR(a_reset_clears, aclk, !aresetn |=> !m_valid)
    `SBCT_ASSERT(a_nohit_zero, aclk, aresetn, m_valid && !m_hit |-> m_entry_time == 17'd0 && m_normal_x == sbct_pkg::NORM_ZERO && m_normal_y == sbct_pkg::NORM_ZERO)
    `SBCT_ASSERT(a_hit_one_normal, aclk, aresetn, m_valid && m_hit |-> (m_normal_x == sbct_pkg::NORM_ZERO) != (m_normal_y == sbct_pkg::NORM_ZERO))
    `SBCT_ASSERT(a_hit_in_frame, aclk, aresetn, m_valid && m_hit |-> m_entry_time <= 17'd65536)

endmodule

// File: design/sbct_front.sv
// Front stages: edges, displacement, broad phase and divider requests.
module sbct_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  sbct_pkg::in_item_t in_item,
    input  logic [7:0]        frame_time,
    output logic              out_valid,
    output sbct_pkg::side_t   out_side,
    output sbct_pkg::div_req_t req_xe,
    output sbct_pkg::div_req_t req_xx,
    output sbct_pkg::div_req_t req_ye,
    output sbct_pkg::div_req_t req_yx
);

    // stage A: box edges and relative velocity
    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic signed [15:0] l1_reg, t1_reg, l2a_reg, t2a_reg;
    logic signed [16:0] r1_reg, b1_reg, r2a_reg, b2a_reg;
    logic signed [16:0] dvx_reg, dvy_reg;
    logic               eqa_reg;

    logic signed [16:0] r1_next, b1_next, r2_next, b2_next, dvx_next, dvy_next;

    always_comb begin
        r1_next  = {in_item.first_left[15], in_item.first_left}
                 + {5'b0, in_item.first_width};
        b1_next  = {in_item.first_top[15], in_item.first_top}
                 + {5'b0, in_item.first_height};
        r2_next  = {in_item.second_left[15], in_item.second_left}
                 + {5'b0, in_item.second_width};
        b2_next  = {in_item.second_top[15], in_item.second_top}
                 + {5'b0, in_item.second_height};
        dvx_next = {in_item.first_speed_x[15], in_item.first_speed_x}
                 - {in_item.second_speed_x[15], in_item.second_speed_x};
        dvy_next = {in_item.first_speed_y[15], in_item.first_speed_y}
                 - {in_item.second_speed_y[15], in_item.second_speed_y};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_reg  <= in_item.first_left;
            t1_reg  <= in_item.first_top;
            l2a_reg <= in_item.second_left;
            t2a_reg <= in_item.second_top;
            r1_reg  <= r1_next;
            b1_reg  <= b1_next;
            r2a_reg <= r2_next;
            b2a_reg <= b2_next;
            dvx_reg <= dvx_next;
            dvy_reg <= dvy_next;
            eqa_reg <= (dvx_next == 17'sd0) && (dvy_next == 17'sd0);
        end
    end

    // stage B: displacement = relative velocity * frame time
    logic signed [25:0] prodx, prody;
    logic signed [24:0] dxb_reg, dyb_reg;
    logic signed [15:0] l1b_reg, t1b_reg, l2b_reg, t2b_reg;
    logic signed [16:0] r1b_reg, b1b_reg, r2b_reg, b2b_reg;
    logic               eqb_reg;

    assign prodx = dvx_reg * $signed({1'b0, frame_time});
    assign prody = dvy_reg * $signed({1'b0, frame_time});

    always_ff @(posedge aclk) begin
        if (en) begin
            dxb_reg <= prodx[24:0];
            dyb_reg <= prody[24:0];
            l1b_reg <= l1_reg;
            t1b_reg <= t1_reg;
            l2b_reg <= l2a_reg;
            t2b_reg <= t2a_reg;
            r1b_reg <= r1_reg;
            b1b_reg <= b1_reg;
            r2b_reg <= r2a_reg;
            b2b_reg <= b2a_reg;
            eqb_reg <= eqa_reg;
        end
    end

    // stage C: swept bounds (pixel shift truncated toward zero) and distances
    logic signed [24:0] dx_adj, dy_adj;
    logic signed [18:0] px, py, l1w, t1w, r1w, b1w, l2w, t2w, r2w, b2w;
    logic signed [18:0] bl_reg, br_reg, bt_reg, bb_reg;
    logic signed [18:0] l2c_reg, r2c_reg, t2c_reg, b2c_reg;
    logic signed [18:0] xe_reg, xx_reg, ye_reg, yx_reg;
    logic signed [24:0] dxc_reg, dyc_reg;
    logic               eqc_reg;

    always_comb begin
        dx_adj = dxb_reg + (dxb_reg[24] ? 25'sd255 : 25'sd0);
        dy_adj = dyb_reg + (dyb_reg[24] ? 25'sd255 : 25'sd0);
        px     = {{2{dx_adj[24]}}, dx_adj[24:8]};
        py     = {{2{dy_adj[24]}}, dy_adj[24:8]};
        l1w    = {{3{l1b_reg[15]}}, l1b_reg};
        t1w    = {{3{t1b_reg[15]}}, t1b_reg};
        l2w    = {{3{l2b_reg[15]}}, l2b_reg};
        t2w    = {{3{t2b_reg[15]}}, t2b_reg};
        r1w    = {{2{r1b_reg[16]}}, r1b_reg};
        b1w    = {{2{b1b_reg[16]}}, b1b_reg};
        r2w    = {{2{r2b_reg[16]}}, r2b_reg};
        b2w    = {{2{b2b_reg[16]}}, b2b_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bl_reg  <= px[18] ? l1w + px : l1w;
            br_reg  <= (!px[18] && px != 19'sd0) ? r1w + px : r1w;
            bt_reg  <= py[18] ? t1w + py : t1w;
            bb_reg  <= (!py[18] && py != 19'sd0) ? b1w + py : b1w;
            l2c_reg <= l2w;
            r2c_reg <= r2w;
            t2c_reg <= t2w;
            b2c_reg <= b2w;
            // moving right: enter at its left edge; otherwise the reverse
            if (!dxb_reg[24] && dxb_reg != 25'sd0) begin
                xe_reg <= l2w - r1w;
                xx_reg <= r2w - l1w;
            end else begin
                xe_reg <= r2w - l1w;
                xx_reg <= l2w - r1w;
            end
            if (!dyb_reg[24] && dyb_reg != 25'sd0) begin
                ye_reg <= t2w - b1w;
                yx_reg <= b2w - t1w;
            end else begin
                ye_reg <= b2w - t1w;
                yx_reg <= t2w - b1w;
            end
            dxc_reg <= dxb_reg;
            dyc_reg <= dyb_reg;
            eqc_reg <= eqb_reg;
        end
    end

    // stage D: strict overlap test and unsigned division requests
    logic               overlap, xinf, yinf;
    logic [18:0]        xe_abs, xx_abs, ye_abs, yx_abs;
    logic [24:0]        dx_abs, dy_abs;
    sbct_pkg::side_t    side_reg;
    sbct_pkg::div_req_t rxe_reg, rxx_reg, rye_reg, ryx_reg;
    logic [sbct_pkg::DEN_W-1:0] denx, deny;

    always_comb begin
        overlap = (bl_reg < br_reg) && (bl_reg < r2c_reg) && (l2c_reg < br_reg)
               && (l2c_reg < r2c_reg) && (bt_reg < bb_reg) && (bt_reg < b2c_reg)
               && (t2c_reg < bb_reg) && (t2c_reg < b2c_reg);
        xinf    = (dxc_reg == 25'sd0);
        yinf    = (dyc_reg == 25'sd0);
        xe_abs  = xe_reg[18] ? 19'(-xe_reg) : xe_reg;
        xx_abs  = xx_reg[18] ? 19'(-xx_reg) : xx_reg;
        ye_abs  = ye_reg[18] ? 19'(-ye_reg) : ye_reg;
        yx_abs  = yx_reg[18] ? 19'(-yx_reg) : yx_reg;
        dx_abs  = dxc_reg[24] ? 25'(-dxc_reg) : dxc_reg;
        dy_abs  = dyc_reg[24] ? 25'(-dyc_reg) : dyc_reg;
        // a zero divisor gives an unused quotient; keep it well defined
        denx    = xinf ? sbct_pkg::DEN_W'(1) : dx_abs[sbct_pkg::DEN_W-1:0];
        deny    = yinf ? sbct_pkg::DEN_W'(1) : dy_abs[sbct_pkg::DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg.nohit  <= eqc_reg || !overlap || (xinf && yinf);
            side_reg.xinf   <= xinf;
            side_reg.yinf   <= yinf;
            side_reg.xe_neg <= xe_reg[18];
            side_reg.ye_neg <= ye_reg[18];
            side_reg.qneg   <= {xe_reg[18] ^ dxc_reg[24], xx_reg[18] ^ dxc_reg[24],
                                ye_reg[18] ^ dyc_reg[24], yx_reg[18] ^ dyc_reg[24]};
            rxe_reg.num <= {xe_abs[sbct_pkg::DIST_W-1:0], (sbct_pkg::FRAC_BITS + 8)'(0)};
            rxx_reg.num <= {xx_abs[sbct_pkg::DIST_W-1:0], (sbct_pkg::FRAC_BITS + 8)'(0)};
            rye_reg.num <= {ye_abs[sbct_pkg::DIST_W-1:0], (sbct_pkg::FRAC_BITS + 8)'(0)};
            ryx_reg.num <= {yx_abs[sbct_pkg::DIST_W-1:0], (sbct_pkg::FRAC_BITS + 8)'(0)};
            rxe_reg.den <= denx;
            rxx_reg.den <= denx;
            rye_reg.den <= deny;
            ryx_reg.den <= deny;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    assign out_valid = vd_reg;
    assign out_side  = side_reg;
    assign req_xe    = rxe_reg;
    assign req_xx    = rxx_reg;
    assign req_ye    = rye_reg;
    assign req_yx    = ryx_reg;

endmodule

// File: design/sbct_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sbct_div (
    input  logic               aclk,
    input  logic               en,
    input  sbct_pkg::div_req_t req,
    output sbct_pkg::div_res_t res
);

    logic [sbct_pkg::DEN_W-1:0] rem_reg  [sbct_pkg::DIV_STAGES];
    logic [sbct_pkg::DEN_W-1:0] rem_next [sbct_pkg::DIV_STAGES];
    logic [sbct_pkg::DEN_W-1:0] den_reg  [sbct_pkg::DIV_STAGES];
    logic [sbct_pkg::DEN_W-1:0] den_next [sbct_pkg::DIV_STAGES];
    logic [sbct_pkg::NUM_W-1:0] nq_reg   [sbct_pkg::DIV_STAGES];
    logic [sbct_pkg::NUM_W-1:0] nq_next  [sbct_pkg::DIV_STAGES];

    // each stage: shift in one dividend bit, trial subtract, quotient bit out
    for (genvar g = 0; g < sbct_pkg::DIV_STAGES; g++) begin : g_stage
        logic [sbct_pkg::DEN_W-1:0] rin;
        logic [sbct_pkg::DEN_W-1:0] din;
        logic [sbct_pkg::NUM_W-1:0] nin;
        logic [sbct_pkg::DEN_W:0]   sh;
        logic [sbct_pkg::DEN_W:0]   diff;

        if (g == 0) begin : g_first
            assign rin = '0;
            assign din = req.den;
            assign nin = req.num;
        end else begin : g_rest
            assign rin = rem_reg[g-1];
            assign din = den_reg[g-1];
            assign nin = nq_reg[g-1];
        end

        assign sh          = {rin, nin[sbct_pkg::NUM_W-1]};
        assign diff        = sh - {1'b0, din};
        assign rem_next[g] = diff[sbct_pkg::DEN_W] ? sh[sbct_pkg::DEN_W-1:0]
                                                   : diff[sbct_pkg::DEN_W-1:0];
        assign den_next[g] = din;
        assign nq_next[g]  = {nin[sbct_pkg::NUM_W-2:0], ~diff[sbct_pkg::DEN_W]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < sbct_pkg::DIV_STAGES; i++) begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_next[i];
                nq_reg[i]  <= nq_next[i];
            end
        end
    end

    assign res.quo    = nq_reg[sbct_pkg::DIV_STAGES-1];
    assign res.rem_nz = |rem_reg[sbct_pkg::DIV_STAGES-1];

endmodule

// File: design/sbct_post.sv
// Back stages: floored signed times, hit decision, normal and result register.
module sbct_post (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  sbct_pkg::side_t    in_side,
    input  sbct_pkg::div_res_t res_xe,
    input  sbct_pkg::div_res_t res_xx,
    input  sbct_pkg::div_res_t res_ye,
    input  sbct_pkg::div_res_t res_yx,
    output logic               out_valid,
    output logic               out_hit,
    output logic [16:0]        out_entry_time,
    output logic signed [1:0]  out_normal_x,
    output logic signed [1:0]  out_normal_y
);

    // floor toward minus infinity for a negative quotient
    function automatic logic signed [sbct_pkg::Q_W-1:0] floor_q(
        input sbct_pkg::div_res_t r,
        input logic               neg
    );
        logic [sbct_pkg::Q_W-1:0] mag;
        mag = {2'b00, r.quo} + {{(sbct_pkg::Q_W-1){1'b0}}, r.rem_nz};
        return neg ? sbct_pkg::Q_W'(-mag) : {2'b00, r.quo};
    endfunction

    // stage P1: signed times
    logic                             v1_reg;
    sbct_pkg::side_t                  side_reg;
    logic signed [sbct_pkg::Q_W-1:0]  txe_reg, txx_reg, tye_reg, tyx_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            txe_reg  <= floor_q(res_xe, in_side.qneg[3]);
            txx_reg  <= floor_q(res_xx, in_side.qneg[2]);
            tye_reg  <= floor_q(res_ye, in_side.qneg[1]);
            tyx_reg  <= floor_q(res_yx, in_side.qneg[0]);
        end
    end

    // stage P2: compares run side by side, then a small selection
    logic                            x_gt_y, ok, xneg, yneg, hit, x_norm;
    logic signed [sbct_pkg::Q_W-1:0] ent, ent16;
    logic signed [1:0]               nx, ny;

    always_comb begin
        x_gt_y = txe_reg > tye_reg;
        if (side_reg.xinf) begin
            ok  = !(tye_reg > tyx_reg);
            ent = tye_reg;
        end else if (side_reg.yinf) begin
            ok  = !(txe_reg > txx_reg);
            ent = txe_reg;
        end else if (x_gt_y) begin
            ok  = (txe_reg <= txx_reg) && (txe_reg <= tyx_reg);
            ent = txe_reg;
        end else begin
            ok  = (tye_reg <= txx_reg) && (tye_reg <= tyx_reg);
            ent = tye_reg;
        end
        xneg = side_reg.xinf || txe_reg[sbct_pkg::Q_W-1];
        yneg = side_reg.yinf || tye_reg[sbct_pkg::Q_W-1];
        hit  = !side_reg.nohit && ok && !(xneg && yneg)
            && (side_reg.xinf || !(txe_reg > sbct_pkg::ONE_TIME))
            && (side_reg.yinf || !(tye_reg > sbct_pkg::ONE_TIME));
        x_norm = !side_reg.xinf && (side_reg.yinf || x_gt_y);
        nx = sbct_pkg::NORM_ZERO;
        ny = sbct_pkg::NORM_ZERO;
        if (x_norm) begin
            nx = side_reg.xe_neg ? sbct_pkg::NORM_POS : sbct_pkg::NORM_NEG;
        end else begin
            ny = side_reg.ye_neg ? sbct_pkg::NORM_POS : sbct_pkg::NORM_NEG;
        end
        ent16 = (sbct_pkg::FRAC_BITS >= 16) ? (ent >>> sbct_pkg::E_SHR)
                                            : (ent <<< sbct_pkg::E_SHL);
    end

    // result register
    logic              vo_reg, hit_reg;
    logic [16:0]       entry_reg;
    logic signed [1:0] nx_reg, ny_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg   <= hit;
            entry_reg <= hit ? ent16[16:0] : 17'd0;
            nx_reg    <= hit ? nx : sbct_pkg::NORM_ZERO;
            ny_reg    <= hit ? ny : sbct_pkg::NORM_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            vo_reg <= v1_reg;
        end
    end

    assign out_valid      = vo_reg;
    assign out_hit        = hit_reg;
    assign out_entry_time = entry_reg;
    assign out_normal_x   = nx_reg;
    assign out_normal_y   = ny_reg;

endmodule
